>>> hw/rtl/fcb_pkg.sv
package fcb_pkg;

  localparam int unsigned NAME_LEN = 8;
  localparam int unsigned EXT_LEN  = 3;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_WILD  = 8'h3F;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_NAME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_EXT  = 8'd1;

  localparam logic [63:0] SPACES_NAME = 64'h2020_2020_2020_2020;
  localparam logic [23:0] SPACES_EXT  = 24'h20_2020;
  localparam logic [63:0] MASK_NAME_RST = 64'h3F3F_3F3F_3F3F_3F3F;
  localparam logic [23:0] MASK_EXT_RST  = 24'h3F_3F3F;

  typedef logic [NAME_LEN-1:0][7:0] name_bytes_t;
  typedef logic [EXT_LEN-1:0][7:0]  ext_bytes_t;

  typedef struct packed {
    name_bytes_t name_field;
    ext_bytes_t  ext_field;
    logic        matches_res;
  } fcb_res_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      u = c - CASE_OFS;
    end
    return u;
  endfunction

  function automatic logic byte_ok(input logic [7:0] f, input logic [7:0] m);
    return (m == CH_WILD) || (to_upper(f) == to_upper(m));
  endfunction

endpackage

>>> hw/rtl/fcb_if.sv
interface fcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface fcb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_field;
  logic [23:0] ext_field;
  logic        matches_res;

  modport source (output valid, output name_field, output ext_field, output matches_res,
                  input ready);
  modport sink   (input valid, input name_field, input ext_field, input matches_res,
                  output ready);
endinterface

interface fcb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fcb_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/fcb_name_convert_and_match.sv
// the last word of a name passes through the input register, then the result register
// throughput: one input word per cycle; one step of the character state per cycle
// a stalled result register holds up only words that end a name
// reset (rst_n low, synchronous): name state cleared to leading dots, buffers to spaces,
// masks to all wildcards, input and result registers emptied
module fcb_name_convert_and_match (
  input logic             clk,
  input logic             rst_n,
  fcb_in_if.sink          in_ch,
  fcb_out_if.source       out_ch,
  fcb_cfg_if.sink         cfg_ch
);

  logic              s0_valid_r;
  logic [7:0]        s0_char_r;
  logic              s0_last_r;
  logic              out_valid_r;
  fcb_pkg::fcb_res_t out_res_r;
  logic [63:0]       mask_name_r;
  logic [23:0]       mask_ext_r;
  fcb_pkg::fcb_res_t res;
  logic              out_free;
  logic              s0_go;
  logic              in_acc;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s0_go        = s0_valid_r && (!s0_last_r || out_free);
  assign in_ch.ready  = !s0_valid_r || s0_go;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_name_r <= fcb_pkg::MASK_NAME_RST;
      mask_ext_r  <= fcb_pkg::MASK_EXT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == fcb_pkg::REG_MASK_NAME) begin
        mask_name_r <= cfg_ch.data;
      end else if (cfg_ch.index == fcb_pkg::REG_MASK_EXT) begin
        mask_ext_r <= cfg_ch.data[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_acc) begin
      s0_valid_r <= 1'b1;
    end else if (s0_go) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_char_r <= in_ch.char_code;
      s0_last_r <= in_ch.last_char;
    end
  end

  fcb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s0_go),
    .char_code (s0_char_r),
    .last_char (s0_last_r),
    .mask_name (mask_name_r),
    .mask_ext  (mask_ext_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_go && s0_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && s0_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.name_field  = out_res_r.name_field;
  assign out_ch.ext_field   = out_res_r.ext_field;
  assign out_ch.matches_res = out_res_r.matches_res;

endmodule

>>> hw/rtl/fcb_core.sv
module fcb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic [63:0]       mask_name,
  input  logic [23:0]       mask_ext,
  output fcb_pkg::fcb_res_t res
);

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_NAME = 3'd1,
    PH_SEEK = 3'd2,
    PH_EXT  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [3:0]           name_pos_r, name_pos_nxt;
  logic [1:0]           ext_pos_r, ext_pos_nxt;
  fcb_pkg::name_bytes_t name_buf_r, name_buf_nxt;
  fcb_pkg::ext_bytes_t  ext_buf_r, ext_buf_nxt;
  fcb_pkg::name_bytes_t mask_n;
  fcb_pkg::ext_bytes_t  mask_e;
  logic [7:0]           c_up;
  logic                 put_n;
  logic                 put_e;
  logic [7:0]           put_val;
  logic                 match;

  assign mask_n = mask_name;
  assign mask_e = mask_ext;
  assign c_up   = fcb_pkg::to_upper(char_code);

  always_comb begin
    phase_nxt    = phase_r;
    name_pos_nxt = name_pos_r;
    ext_pos_nxt  = ext_pos_r;
    name_buf_nxt = name_buf_r;
    ext_buf_nxt  = ext_buf_r;
    put_n        = 1'b0;
    put_e        = 1'b0;
    put_val      = c_up;
    if (char_code == fcb_pkg::CH_NUL) begin
      phase_nxt = PH_DONE;
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (char_code == fcb_pkg::CH_DOT) begin
            put_n   = 1'b1;
            put_val = char_code;
          end else if (char_code != fcb_pkg::CH_SPACE) begin
            phase_nxt = PH_NAME;
            put_n     = 1'b1;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (char_code == fcb_pkg::CH_DOT) begin
            phase_nxt = PH_EXT;
          end else if (char_code != fcb_pkg::CH_SPACE) begin
            put_n = 1'b1;
          end
        end
        PH_SEEK: begin
          if (char_code == fcb_pkg::CH_DOT) begin
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          if (char_code == fcb_pkg::CH_DOT || char_code == fcb_pkg::CH_SPACE) begin
            phase_nxt = PH_DONE;
          end else begin
            put_e = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (put_n) begin
      name_buf_nxt[~name_pos_r[2:0]] = put_val;
      name_pos_nxt = name_pos_r + 4'd1;
      if (name_pos_nxt >= 4'(fcb_pkg::NAME_LEN)) begin
        phase_nxt = PH_SEEK;
      end
    end
    if (put_e) begin
      ext_buf_nxt[2'd2 - ext_pos_r] = put_val;
      ext_pos_nxt = ext_pos_r + 2'd1;
      if (ext_pos_nxt >= 2'(fcb_pkg::EXT_LEN)) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < fcb_pkg::NAME_LEN; k++) begin
      match = match & fcb_pkg::byte_ok(name_buf_nxt[k], mask_n[k]);
    end
    for (int k = 0; k < fcb_pkg::EXT_LEN; k++) begin
      match = match & fcb_pkg::byte_ok(ext_buf_nxt[k], mask_e[k]);
    end
  end

  assign res.name_field  = name_buf_nxt;
  assign res.ext_field   = ext_buf_nxt;
  assign res.matches_res = match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      name_pos_r <= '0;
      ext_pos_r  <= '0;
      name_buf_r <= fcb_pkg::SPACES_NAME;
      ext_buf_r  <= fcb_pkg::SPACES_EXT;
    end else if (step) begin
      if (last_char) begin
        phase_r    <= PH_LEAD;
        name_pos_r <= '0;
        ext_pos_r  <= '0;
        name_buf_r <= fcb_pkg::SPACES_NAME;
        ext_buf_r  <= fcb_pkg::SPACES_EXT;
      end else begin
        phase_r    <= phase_nxt;
        name_pos_r <= name_pos_nxt;
        ext_pos_r  <= ext_pos_nxt;
        name_buf_r <= name_buf_nxt;
        ext_buf_r  <= ext_buf_nxt;
      end
    end
  end

  a_name_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    name_pos_r <= 4'(fcb_pkg::NAME_LEN))
    else $error("name position out of range");

  a_seek_full: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEEK |-> name_pos_r == 4'(fcb_pkg::NAME_LEN))
    else $error("seek phase with name part not full");

  a_ext_room: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXT |-> ext_pos_r < 2'(fcb_pkg::EXT_LEN))
    else $error("extension phase with extension full");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_char |=> phase_r == PH_LEAD && name_pos_r == 4'd0 && ext_pos_r == 2'd0)
    else $error("state not cleared after last word");

endmodule

>>> tb/tb_fcb_name_convert_and_match.sv
`timescale 1ns / 1ps

module tb_fcb_name_convert_and_match;

  typedef enum logic [2:0] {
    ST_LEAD = 3'd0,
    ST_NAME = 3'd1,
    ST_SEEK = 3'd2,
    ST_EXT  = 3'd3,
    ST_DONE = 3'd4
  } name_state_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned WORDS_PER_PHASE = 130;

  logic clk = 1'b0;
  logic rst_n;

  fcb_in_if  in_ch ();
  fcb_out_if out_ch ();
  fcb_cfg_if cfg_ch ();

  fcb_name_convert_and_match i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted block state and masks
  fcb_pkg::name_bytes_t mask_name_q;
  fcb_pkg::ext_bytes_t  mask_ext_q;
  name_state_t          name_state;
  logic [3:0]           name_cnt;
  logic [1:0]           ext_cnt;
  fcb_pkg::name_bytes_t name_acc;
  fcb_pkg::ext_bytes_t  ext_acc;

  char_word_t          chars_to_send[$];
  fcb_pkg::fcb_res_t   fcb_blocks_due[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned in_quiet = 0;
  int unsigned out_gap = 0;
  int unsigned out_quiet = 0;
  logic        in_taken = 1'b0;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= fcb_pkg::CH_LO_A && c <= fcb_pkg::CH_LO_Z) ? c - fcb_pkg::CASE_OFS : c;
  endfunction

  function automatic logic block_matches();
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < fcb_pkg::NAME_LEN; k++) begin
      if (mask_name_q[k] != fcb_pkg::CH_WILD &&
          fold_case(name_acc[k]) != fold_case(mask_name_q[k])) begin
        hit = 1'b0;
      end
    end
    for (int k = 0; k < fcb_pkg::EXT_LEN; k++) begin
      if (mask_ext_q[k] != fcb_pkg::CH_WILD &&
          fold_case(ext_acc[k]) != fold_case(mask_ext_q[k])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic void clear_name_state();
    name_state = ST_LEAD;
    name_cnt   = '0;
    ext_cnt    = '0;
    name_acc   = fcb_pkg::SPACES_NAME;
    ext_acc    = fcb_pkg::SPACES_EXT;
  endfunction

  function automatic void store_name_byte(input logic [7:0] c);
    name_acc[3'd7 - name_cnt[2:0]] = c;
    name_cnt++;
    if (name_cnt >= fcb_pkg::NAME_LEN) begin
      name_state = ST_SEEK;
    end
  endfunction

  function automatic void store_ext_byte(input logic [7:0] c);
    ext_acc[2'd2 - ext_cnt] = c;
    ext_cnt++;
    if (ext_cnt >= fcb_pkg::EXT_LEN) begin
      name_state = ST_DONE;
    end
  endfunction

  function automatic logic predict_fcb(input char_word_t w, output fcb_pkg::fcb_res_t blk);
    logic [7:0] up;
    up  = fold_case(w.code);
    blk = '0;
    if (w.code == fcb_pkg::CH_NUL) begin
      name_state = ST_DONE;
    end else if (name_state == ST_LEAD && w.code == fcb_pkg::CH_DOT) begin
      store_name_byte(w.code);
    end else begin
      if (name_state == ST_LEAD) begin
        name_state = ST_NAME;
      end
      case (name_state)
        ST_NAME: begin
          if (w.code == fcb_pkg::CH_DOT) begin
            name_state = ST_EXT;
          end else if (w.code != fcb_pkg::CH_SPACE) begin
            store_name_byte(up);
          end
        end
        ST_SEEK: begin
          if (w.code == fcb_pkg::CH_DOT) begin
            name_state = ST_EXT;
          end
        end
        ST_EXT: begin
          if (w.code == fcb_pkg::CH_DOT || w.code == fcb_pkg::CH_SPACE) begin
            name_state = ST_DONE;
          end else begin
            store_ext_byte(up);
          end
        end
        default: begin
        end
      endcase
    end
    if (!w.last) begin
      return 1'b0;
    end
    blk.name_field  = name_acc;
    blk.ext_field   = ext_acc;
    blk.matches_res = block_matches();
    clear_name_state();
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, and now and then a quiet stretch
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 80);
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_name(input logic [7:0] s[$]);
    char_word_t w;
    foreach (s[i]) begin
      w.code = s[i];
      w.last = (i == s.size() - 1);
      chars_to_send.push_back(w);
    end
  endfunction

  function automatic void queue_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) begin
      s.push_back(t[i]);
    end
    queue_name(s);
  endfunction

  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return CH_UP_A + 8'($urandom_range(0, 25));
    end
    if (r < 65) begin
      return fcb_pkg::CH_LO_A + 8'($urandom_range(0, 25));
    end
    if (r < 75) begin
      return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    end
    if (r < 80) begin
      return fcb_pkg::CH_SPACE;
    end
    if (r < 90) begin
      case ($urandom_range(0, 5))
        0: return 8'h40;
        1: return 8'h5B;
        2: return 8'h60;
        3: return 8'h7B;
        4: return fcb_pkg::CH_WILD;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void queue_file_name();
    logic [7:0] s[$];
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 9)) s.push_back(fcb_pkg::CH_DOT);
      end
      repeat ($urandom_range(0, 10)) s.push_back(pick_name_char());
      if ($urandom_range(0, 99) < 85) begin
        s.push_back(fcb_pkg::CH_DOT);
        repeat ($urandom_range(0, 4)) s.push_back(pick_name_char());
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          s.push_back(($urandom_range(0, 3) == 0) ? fcb_pkg::CH_DOT : pick_name_char());
        end
      end
      if (s.size() == 0) begin
        s.push_back(pick_name_char());
      end
      if ($urandom_range(0, 19) == 0) begin
        s.insert($urandom_range(0, s.size() - 1), fcb_pkg::CH_NUL);
      end
    end
    queue_name(s);
  endfunction

  function automatic void queue_tmpl_name(input logic [7:0] tn[$], input logic [7:0] te[$]);
    logic [7:0] s[$];
    logic [7:0] c;
    foreach (tn[i]) begin
      c = tn[i];
      if ($urandom_range(0, 1) == 1) begin
        c = c + fcb_pkg::CASE_OFS;
      end
      s.push_back(c);
    end
    if (te.size() != 0 || $urandom_range(0, 1) == 1) begin
      s.push_back(fcb_pkg::CH_DOT);
    end
    foreach (te[i]) begin
      c = te[i];
      if ($urandom_range(0, 1) == 1) begin
        c = c + fcb_pkg::CASE_OFS;
      end
      s.push_back(c);
    end
    queue_name(s);
  endfunction

  function automatic logic [7:0] pick_mask_byte(input logic [7:0] c);
    case ($urandom_range(0, 9))
      0, 1, 2: return fcb_pkg::CH_WILD;
      3, 4, 5: return c + fcb_pkg::CASE_OFS;
      default: return c;
    endcase
  endfunction

  task automatic write_reg(input logic [fcb_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == fcb_pkg::REG_MASK_NAME) begin
      mask_name_q = val;
    end else if (idx == fcb_pkg::REG_MASK_EXT) begin
      mask_ext_q = val[23:0];
    end
  endtask

  task automatic set_masks(input fcb_pkg::name_bytes_t mn, input fcb_pkg::ext_bytes_t me);
    logic [63:0] ext_word;
    ext_word = {$urandom(), $urandom()};
    ext_word[23:0] = me;
    write_reg(fcb_pkg::REG_MASK_NAME, mn);
    write_reg(fcb_pkg::REG_MASK_EXT, ext_word);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (chars_to_send.size() != 0 || in_ch.valid || fcb_blocks_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input word driver
  always @(negedge clk) begin
    char_word_t word;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (chars_to_send.size() != 0) begin
        word = chars_to_send.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= word.code;
        in_ch.last_char <= word.last;
        in_gap = pick_gap(in_quiet);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = pick_gap(out_quiet);
    end
  end

  always @(posedge clk) begin
    char_word_t        w;
    fcb_pkg::fcb_res_t blk;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.code = in_ch.char_code;
      w.last = in_ch.last_char;
      if (predict_fcb(w, blk)) begin
        fcb_blocks_due.push_back(blk);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fcb_blocks_due.size() == 0) begin
        $error("result word with no file name pending");
        mismatches++;
      end else begin
        blk = fcb_blocks_due.pop_front();
        if (out_ch.name_field !== blk.name_field) begin
          $error("name_field: expected %h, got %h", blk.name_field, out_ch.name_field);
          mismatches++;
        end
        if (out_ch.ext_field !== blk.ext_field) begin
          $error("ext_field: expected %h, got %h", blk.ext_field, out_ch.ext_field);
          mismatches++;
        end
        if (out_ch.matches_res !== blk.matches_res) begin
          $error("matches_res: expected %b, got %b", blk.matches_res, out_ch.matches_res);
          mismatches++;
        end
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fcb_name_convert_and_match regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]           s[$];
    logic [7:0]           tn[$];
    logic [7:0]           te[$];
    fcb_pkg::name_bytes_t mn;
    fcb_pkg::ext_bytes_t  me;
    int unsigned          n0;
    int unsigned          sent;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    mask_name_q     = fcb_pkg::MASK_NAME_RST;
    mask_ext_q      = fcb_pkg::MASK_EXT_RST;
    clear_name_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // eight leading dots, dropped byte, then extension
    queue_text("........x.a");
    // space before a dot, top byte in the extension
    s = '{8'h66, fcb_pkg::CH_SPACE, fcb_pkg::CH_DOT, 8'hFF};
    queue_name(s);
    // case boundaries, then a terminator with a trailing byte
    s = '{8'h7B, 8'h60, fcb_pkg::CH_NUL, 8'h7A};
    queue_name(s);
    // bytes after a full extension
    queue_text("q.abcd");

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      tn.delete();
      te.delete();
      repeat ($urandom_range(1, fcb_pkg::NAME_LEN)) begin
        tn.push_back(CH_UP_A + 8'($urandom_range(0, 25)));
      end
      repeat ($urandom_range(0, fcb_pkg::EXT_LEN)) begin
        te.push_back(CH_UP_A + 8'($urandom_range(0, 25)));
      end
      case (p)
        0: set_masks('0, '0);
        1: set_masks('1, '1);
        2: set_masks(fcb_pkg::MASK_NAME_RST, fcb_pkg::MASK_EXT_RST);
        3: set_masks(fcb_pkg::SPACES_NAME, fcb_pkg::SPACES_EXT);
        default: begin
          for (int k = 0; k < fcb_pkg::NAME_LEN; k++) begin
            mn[fcb_pkg::NAME_LEN - 1 - k] = (k < tn.size()) ? pick_mask_byte(tn[k]) :
                (($urandom_range(0, 3) == 0) ? fcb_pkg::CH_WILD : fcb_pkg::CH_SPACE);
          end
          for (int k = 0; k < fcb_pkg::EXT_LEN; k++) begin
            me[fcb_pkg::EXT_LEN - 1 - k] = (k < te.size()) ? pick_mask_byte(te[k]) :
                (($urandom_range(0, 3) == 0) ? fcb_pkg::CH_WILD : fcb_pkg::CH_SPACE);
          end
          set_masks(mn, me);
        end
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        n0 = chars_to_send.size();
        if (p >= 4 && $urandom_range(0, 99) < 40) begin
          queue_tmpl_name(tn, te);
        end else begin
          queue_file_name();
        end
        sent += chars_to_send.size() - n0;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("fcb_name_convert_and_match regression: pass");
    end else begin
      $display("fcb_name_convert_and_match regression: fail");
    end
    $finish;
  end

endmodule
